// File: hdl/cdsr_pkg.sv
`timescale 1ns / 1ps

package cdsr_pkg;

    // default sizing
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed payload widths on the channels
    localparam int OPCODE_W    = 3;
    localparam int VALUE_IN_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int VALUE_OUT_W = 32;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_FIND      = 3'd4,
        OP_REMOVE    = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

endpackage

// File: hdl/cdsr_ifs.sv
`timescale 1ns / 1ps

// operation channel
interface cdsr_cmd_if;
    logic                             valid;
    logic                             ready;
    cdsr_pkg::op_t                    opcode;
    logic [cdsr_pkg::VALUE_IN_W-1:0]  value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

// result channel
interface cdsr_rsp_if;
    logic                             valid;
    logic                             ready;
    cdsr_pkg::status_t                status;
    logic [cdsr_pkg::VALUE_OUT_W-1:0] value_out;
    logic [cdsr_pkg::SLOT_W-1:0]      slot_found;
    logic [cdsr_pkg::COUNT_W-1:0]     count_after;

    modport source (output valid, output status, output value_out, output slot_found,
                    output count_after, input ready);
    modport sink   (input valid, input status, input value_out, input slot_found,
                    input count_after, output ready);
endinterface

// File: hdl/cdsr_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read
module cdsr_ram #(
    parameter int WIDTH = cdsr_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = cdsr_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/circular_deque_with_search_remove_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                       Transfer
// -------  ---  --------------------------------------------  ------------------
// cmd      in   opcode[2:0], value_in[31:0]                   valid && ready
// rsp      out  status[1:0], value_out[31:0], slot_found[5:0], valid && ready
//               count_after[6:0]
//
// One operation at a time. A push or a refused/undefined op parks its result directly,
// a pop first reads the popped slot, a find compares entries from the head onward,
// and a remove then moves the entries on one side of the gap (fewer than CAPACITY).
// The scan and the gap close both run through the single read port of the slot
// RAM, one entry per cycle.
// Reset clears pointers, count and the output valid; the slot RAM is not cleared.
// A stalled rsp holds its result; the next op is still taken meanwhile and parks
// its result until the output register is free.
module circular_deque_with_search_remove_top #(
    parameter int CAPACITY    = cdsr_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = cdsr_pkg::VALUE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cdsr_cmd_if.sink     cmd,
    cdsr_rsp_if.source   rsp
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // overlap widths for resizing between internal and port widths
    localparam int VI_W = (VALUE_WIDTH < cdsr_pkg::VALUE_IN_W) ? VALUE_WIDTH
                                                               : cdsr_pkg::VALUE_IN_W;
    localparam int VO_W = (VALUE_WIDTH < cdsr_pkg::VALUE_OUT_W) ? VALUE_WIDTH
                                                                : cdsr_pkg::VALUE_OUT_W;
    localparam int SL_W = (PTR_W < cdsr_pkg::SLOT_W) ? PTR_W : cdsr_pkg::SLOT_W;
    localparam int CO_W = (CNT_W < cdsr_pkg::COUNT_W) ? CNT_W : cdsr_pkg::COUNT_W;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POP   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] val_from_in(
        input logic [cdsr_pkg::VALUE_IN_W-1:0] v);
        logic [VALUE_WIDTH-1:0] r;
        r = '0;
        r[VI_W-1:0] = v[VI_W-1:0];
        return r;
    endfunction

    function automatic logic [cdsr_pkg::VALUE_OUT_W-1:0] val_to_out(
        input logic [VALUE_WIDTH-1:0] v);
        logic [cdsr_pkg::VALUE_OUT_W-1:0] r;
        r = '0;
        r[VO_W-1:0] = v[VO_W-1:0];
        return r;
    endfunction

    function automatic logic [cdsr_pkg::SLOT_W-1:0] slot_to_out(input logic [PTR_W-1:0] p);
        logic [cdsr_pkg::SLOT_W-1:0] r;
        r = '0;
        r[SL_W-1:0] = p[SL_W-1:0];
        return r;
    endfunction

    function automatic logic [cdsr_pkg::COUNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] c);
        logic [cdsr_pkg::COUNT_W-1:0] r;
        r = '0;
        r[CO_W-1:0] = c[CO_W-1:0];
        return r;
    endfunction

    // control state
    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // working registers of the current op
    cdsr_pkg::op_t          op_reg, op_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [PTR_W-1:0]       scan_addr_reg, scan_addr_next;   // next slot to read
    logic [CNT_W-1:0]       scan_left_reg, scan_left_next;   // entries not yet read
    logic [PTR_W-1:0]       cmp_addr_reg, cmp_addr_next;     // slot now in rdata
    logic [PTR_W-1:0]       sh_src_reg, sh_src_next;
    logic [PTR_W-1:0]       sh_dst_reg, sh_dst_next;
    logic [PTR_W-1:0]       sh_left_reg, sh_left_next;
    logic                   sh_down_reg, sh_down_next;

    // parked result and output register
    cdsr_pkg::status_t                res_status_reg, res_status_next;
    logic [cdsr_pkg::VALUE_OUT_W-1:0] res_value_reg, res_value_next;
    logic [cdsr_pkg::SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [cdsr_pkg::COUNT_W-1:0]     res_count_reg, res_count_next;
    cdsr_pkg::status_t                out_status_reg, out_status_next;
    logic [cdsr_pkg::VALUE_OUT_W-1:0] out_value_reg, out_value_next;
    logic [cdsr_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [cdsr_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    // slot RAM port
    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [PTR_W-1:0]       ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic                   cmd_xfer;
    logic                   out_free;
    logic [VALUE_WIDTH-1:0] val_in_w;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       count_dec;
    logic [PTR_W-1:0]       push_slot;

    cdsr_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign cmd_xfer        = cmd.valid && cmd.ready;
    assign out_free        = !out_valid_reg || rsp.ready;
    assign val_in_w        = val_from_in(cmd.value_in);
    assign count_inc       = count_reg + 1'b1;
    assign count_dec       = count_reg - 1'b1;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.value_out   = out_value_reg;
    assign rsp.slot_found  = out_slot_reg;
    assign rsp.count_after = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        scan_addr_next  = scan_addr_reg;
        scan_left_next  = scan_left_reg;
        cmp_addr_next   = cmp_addr_reg;
        sh_src_next     = sh_src_reg;
        sh_dst_next     = sh_dst_reg;
        sh_left_next    = sh_left_reg;
        sh_down_next    = sh_down_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = val_in_w;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        push_slot       = head_reg;

        // output register drains on its own transfer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    op_next         = cmd.opcode;
                    val_next        = val_in_w;
                    res_status_next = cdsr_pkg::STS_OK;
                    res_value_next  = '0;
                    res_slot_next   = '0;
                    res_count_next  = cnt_to_out(count_reg);
                    state_next      = ST_DONE;
                    case (cmd.opcode) inside
                        cdsr_pkg::OP_PUSH_HEAD, cdsr_pkg::OP_PUSH_TAIL:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_status_next = cdsr_pkg::STS_FULL;
                            end
                            else
                            begin
                                // first push into an empty deque keeps the pointer
                                if (cmd.opcode == cdsr_pkg::OP_PUSH_HEAD)
                                begin
                                    push_slot = (count_reg != '0) ? ptr_prev(head_reg)
                                                                  : head_reg;
                                    head_next = push_slot;
                                end
                                else
                                begin
                                    push_slot = (count_reg != '0) ? ptr_next(tail_reg)
                                                                  : tail_reg;
                                    tail_next = push_slot;
                                end
                                ram_we         = 1'b1;
                                ram_waddr      = push_slot;
                                count_next     = count_inc;
                                res_value_next = val_to_out(val_in_w);
                                res_count_next = cnt_to_out(count_inc);
                            end
                        end
                        cdsr_pkg::OP_POP_HEAD, cdsr_pkg::OP_POP_TAIL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = cdsr_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                count_next     = count_dec;
                                res_count_next = cnt_to_out(count_dec);
                                state_next     = ST_POP;
                                if (cmd.opcode == cdsr_pkg::OP_POP_HEAD)
                                begin
                                    ram_raddr = head_reg;
                                    if (count_reg != CNT_W'(1))
                                    begin
                                        head_next = ptr_next(head_reg);
                                    end
                                end
                                else
                                begin
                                    ram_raddr = tail_reg;
                                    if (count_reg != CNT_W'(1))
                                    begin
                                        tail_next = ptr_prev(tail_reg);
                                    end
                                end
                            end
                        end
                        cdsr_pkg::OP_FIND, cdsr_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = cdsr_pkg::STS_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = head_reg;
                                cmp_addr_next  = head_reg;
                                scan_addr_next = ptr_next(head_reg);
                                scan_left_next = count_dec;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // undefined op: plain ok with the count unchanged
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                res_value_next = val_to_out(ram_rdata);
                state_next     = ST_DONE;
            end

            ST_SCAN:
            begin
                if (ram_rdata == val_reg)
                begin
                    res_value_next = val_to_out(val_reg);
                    state_next     = ST_DONE;
                    if (op_reg == cdsr_pkg::OP_FIND)
                    begin
                        res_slot_next = slot_to_out(cmp_addr_reg);
                    end
                    else
                    begin
                        count_next     = count_dec;
                        res_count_next = cnt_to_out(count_dec);
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (cmp_addr_reg == head_reg)
                        begin
                            head_next = ptr_next(head_reg);
                        end
                        else if (cmp_addr_reg == tail_reg)
                        begin
                            tail_next = ptr_prev(tail_reg);
                        end
                        else if (cmp_addr_reg < tail_reg)
                        begin
                            // interior below the tail: pull the upper run down a slot
                            ram_re       = 1'b1;
                            ram_raddr    = cmp_addr_reg + 1'b1;
                            sh_src_next  = cmp_addr_reg + PTR_W'(2);
                            sh_dst_next  = cmp_addr_reg;
                            sh_left_next = tail_reg - cmp_addr_reg - 1'b1;
                            sh_down_next = 1'b1;
                            tail_next    = tail_reg - 1'b1;
                            state_next   = ST_SHIFT;
                        end
                        else
                        begin
                            // interior above the head: push the lower run up a slot
                            ram_re       = 1'b1;
                            ram_raddr    = cmp_addr_reg - 1'b1;
                            sh_src_next  = cmp_addr_reg - PTR_W'(2);
                            sh_dst_next  = cmp_addr_reg;
                            sh_left_next = cmp_addr_reg - head_reg - 1'b1;
                            sh_down_next = 1'b0;
                            head_next    = ptr_next(head_reg);
                            state_next   = ST_SHIFT;
                        end
                    end
                end
                else if (scan_left_reg == '0)
                begin
                    res_status_next = cdsr_pkg::STS_NOT_FOUND;
                    state_next      = ST_DONE;
                end
                else
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg;
                    cmp_addr_next  = scan_addr_reg;
                    scan_addr_next = ptr_next(scan_addr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
            end

            ST_SHIFT:
            begin
                // write back the entry read last cycle, read the next one
                ram_we    = 1'b1;
                ram_waddr = sh_dst_reg;
                ram_wdata = ram_rdata;
                if (sh_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = sh_src_reg;
                    sh_left_next = sh_left_reg - 1'b1;
                    if (sh_down_reg)
                    begin
                        sh_src_next = sh_src_reg + 1'b1;
                        sh_dst_next = sh_dst_reg + 1'b1;
                    end
                    else
                    begin
                        sh_src_next = sh_src_reg - 1'b1;
                        sh_dst_next = sh_dst_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_slot_next   = res_slot_reg;
                    out_count_next  = res_count_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        scan_addr_reg  <= scan_addr_next;
        scan_left_reg  <= scan_left_next;
        cmp_addr_reg   <= cmp_addr_next;
        sh_src_reg     <= sh_src_next;
        sh_dst_reg     <= sh_dst_next;
        sh_left_reg    <= sh_left_next;
        sh_down_reg    <= sh_down_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
    end

    // gap close never reads the slot it writes in the same cycle
    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && sh_left_reg != '0) |-> sh_src_reg != sh_dst_reg)
        else $error("shift read and write hit the same slot");

    // an empty deque keeps both pointers together
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty deque with split pointers");

    // an accepted push into a non-full deque adds exactly one entry
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_xfer && count_reg != FULL_CNT &&
         (cmd.opcode == cdsr_pkg::OP_PUSH_HEAD || cmd.opcode == cdsr_pkg::OP_PUSH_TAIL))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the count by one");

    // a parked result reaches the output register once it is free
    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (rsp.valid && state_reg == ST_IDLE))
        else $error("parked result not delivered");

endmodule
